### hw/rtl/lae_pkg.sv
// ----------------------------------------------------------------------------
// lae_pkg
// Shared codes, record types and helpers of the actionpoint evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package lae_pkg;

  localparam int POINT_COUNT_DEF     = 256;
  localparam int WATCH_COUNT_DEF     = 256;
  localparam int EQUATION_LENGTH_DEF = 32;

  // operations
  localparam logic [1:0] OP_LOAD_WATCH = 2'd0;
  localparam logic [1:0] OP_LOAD_TOKEN = 2'd1;
  localparam logic [1:0] OP_LOAD_SET   = 2'd2;
  localparam logic [1:0] OP_SAMPLE     = 2'd3;

  // equation operator tokens
  localparam logic [15:0] TOK_AND = 16'hFFFF;
  localparam logic [15:0] TOK_OR  = 16'hFFFE;
  localparam logic [15:0] TOK_XOR = 16'hFFFD;
  localparam logic [15:0] TOK_NOT = 16'hFFFC;
  localparam logic [15:0] TOK_END = 16'hFFFB;

  // watch values
  localparam logic [1:0] W_FALSE = 2'd0;
  localparam logic [1:0] W_TRUE  = 2'd1;
  localparam logic [1:0] W_ERROR = 2'd2;
  localparam logic [1:0] W_STALE = 2'd3;

  // outcomes
  localparam logic [1:0] R_PASS  = 2'd0;
  localparam logic [1:0] R_FAIL  = 2'd1;
  localparam logic [1:0] R_STALE = 2'd2;
  localparam logic [1:0] R_ERROR = 2'd3;

  // point states
  localparam logic [2:0] PS_UNUSED  = 3'd0;
  localparam logic [2:0] PS_ACTIVE  = 3'd1;
  localparam logic [2:0] PS_PASSIVE = 3'd2;
  localparam logic [2:0] PS_LAST    = 3'd4;

  // setting selects
  localparam logic [2:0] SEL_STATE   = 3'd0;
  localparam logic [2:0] SEL_FAILS   = 3'd1;
  localparam logic [2:0] SEL_PF      = 3'd2;
  localparam logic [2:0] SEL_FP      = 3'd3;
  localparam logic [2:0] SEL_PASSIVE = 3'd4;
  localparam logic [2:0] SEL_ACTION  = 3'd5;

  // event flag bits
  localparam int FL_PF      = 0;
  localparam int FL_FP      = 1;
  localparam int FL_ACTION  = 2;
  localparam int FL_APP_PAS = 3;
  localparam int FL_PT_PAS  = 4;
  localparam int FL_BAD     = 5;
  localparam int FL_ERROR   = 6;

  typedef struct packed {
    logic [2:0]  state;
    logic [1:0]  last;
    logic [31:0] consec;
    logic [31:0] pf;
    logic [31:0] fp;
    logic [31:0] pas;
  } rec_t;

  typedef struct packed {
    logic [15:0] fails;
    logic [15:0] pf;
    logic [15:0] fp;
    logic [15:0] pas;
    logic [15:0] action;
  } set_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] c);
    sat_inc = (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
  endfunction

  function automatic logic [1:0] combine(input logic [15:0] t, input logic [1:0] a,
                                         input logic [1:0] b);
    logic [1:0] r;
    if (t == TOK_AND && (a == W_FALSE || b == W_FALSE)) r = W_FALSE;
    else if (t == TOK_OR && (a == W_TRUE || b == W_TRUE)) r = W_TRUE;
    else if (a == W_ERROR || b == W_ERROR) r = W_ERROR;
    else if (a == W_STALE || b == W_STALE) r = W_STALE;
    else if (t == TOK_AND) r = W_TRUE;
    else if (t == TOK_OR) r = W_FALSE;
    else r = (a != b) ? W_TRUE : W_FALSE;
    combine = r;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/limit_actionpoint_evaluator_top.sv
// ----------------------------------------------------------------------------
// limit_actionpoint_evaluator_top
// Watch results, postfix actionpoint equations, fail counters and actions.
// ----------------------------------------------------------------------------
// load watch or token beat: written on start; setting beat: written in SETW
// sample beat: CHK reads the record and ends a point not active or passive;
// else TOK takes each token, operators in place, watch tokens via PUSH, until
// an end token or error leads to UPD; one token and one watch RAM read per step
// busy is high while an item is in work; results are strobed by done_o
// after reset a clearing pass over max(POINT_COUNT, WATCH_COUNT) entries holds busy
`default_nettype none

module limit_actionpoint_evaluator_top #(
  parameter int POINT_COUNT     = lae_pkg::POINT_COUNT_DEF,
  parameter int WATCH_COUNT     = lae_pkg::WATCH_COUNT_DEF,
  parameter int EQUATION_LENGTH = lae_pkg::EQUATION_LENGTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        app_active_we_i,
  input  wire logic        app_active_i,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [1:0]  operation_i,
  input  wire logic [7:0]  ap_index_i,
  input  wire logic [7:0]  watch_index_i,
  input  wire logic [1:0]  watch_value_i,
  input  wire logic [4:0]  token_position_i,
  input  wire logic [15:0] token_value_i,
  input  wire logic [2:0]  setting_select_i,
  input  wire logic [15:0] setting_value_i,
  output logic             done_o,
  output logic             sampled_o,
  output logic [1:0]       outcome_o,
  output logic [2:0]       point_state_o,
  output logic [15:0]      consecutive_fails_o,
  output logic             request_action_o,
  output logic [15:0]      action_id_o,
  output logic [6:0]       event_flags_o
);

  import lae_pkg::*;

  localparam int PAW  = POINT_COUNT > 1 ? $clog2(POINT_COUNT) : 1;
  localparam int WAW  = WATCH_COUNT > 1 ? $clog2(WATCH_COUNT) : 1;
  localparam int EW   = $clog2(EQUATION_LENGTH);
  localparam int PW   = $clog2(EQUATION_LENGTH + 1);
  localparam int SW   = 2 * EQUATION_LENGTH;
  localparam int CLRN = POINT_COUNT > WATCH_COUNT ? POINT_COUNT : WATCH_COUNT;
  localparam int CLW  = PAW > WAW ? PAW : WAW;
  localparam int RW   = $bits(rec_t);
  localparam int STW  = $bits(set_t);

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_SETW = 3'd2;
  localparam logic [2:0] ST_CHK  = 3'd3;
  localparam logic [2:0] ST_TOK  = 3'd4;
  localparam logic [2:0] ST_PUSH = 3'd5;
  localparam logic [2:0] ST_UPD  = 3'd6;

  logic [2:0]     st_q, st_d;
  logic [PAW-1:0] ap_q, ap_d;
  logic [2:0]     sel_q, sel_d;
  logic [15:0]    sval_q, sval_d;
  logic [PW-1:0]  pos_q, pos_d;
  logic [PW-1:0]  sp_q, sp_d;
  logic [SW-1:0]  stk_q, stk_d;
  logic [1:0]     cur_q, cur_d;
  logic           bad_q, bad_d;
  logic [CLW-1:0] clr_q, clr_d;
  logic           app_q;

  logic        done_q, done_d;
  logic        sampled_q, sampled_d;
  logic [1:0]  outcome_q, outcome_d;
  logic [2:0]  pstate_q, pstate_d;
  logic [15:0] consec_q, consec_d;
  logic        req_q, req_d;
  logic [15:0] act_q, act_d;
  logic [6:0]  flags_q, flags_d;

  // memory ports
  logic           watch_we;
  logic [WAW-1:0] watch_waddr, watch_raddr;
  logic [1:0]     watch_wdata, watch_rdata;
  logic           tok_we;
  logic [PAW+EW-1:0] tok_waddr, tok_raddr;
  logic [15:0]    tok_rdata;
  logic           rec_we, set_we;
  logic [PAW-1:0] rec_waddr, rec_raddr;
  logic [RW-1:0]  rec_rdata_raw;
  logic [STW-1:0] set_rdata_raw;
  rec_t           rec_r, rec_n;
  set_t           set_r, set_n;

  logic           ap_ok;
  logic [1:0]     top_v;
  logic [31:0]    c1, pf1, fp1, pas1;

  assign rec_r     = rec_t'(rec_rdata_raw);
  assign set_r     = set_t'(set_rdata_raw);
  assign ap_ok     = 32'(ap_index_i) < POINT_COUNT;
  assign rec_raddr = (st_q == ST_IDLE) ? PAW'(ap_index_i) : ap_q;
  assign tok_raddr = {ap_q, pos_d[EW-1:0]};
  assign watch_raddr = WAW'(tok_rdata);
  assign top_v     = stk_q[1:0];
  assign c1        = sat_inc(rec_r.consec);
  assign pf1       = sat_inc(rec_r.pf);
  assign fp1       = sat_inc(rec_r.fp);
  assign pas1      = sat_inc(rec_r.pas);

  lae_ram #(.WIDTH(2), .DEPTH(WATCH_COUNT)) u_watch_ram (
    .clk_i   (clk_i),
    .we_i    (watch_we),
    .waddr_i (watch_waddr),
    .wdata_i (watch_wdata),
    .raddr_i (watch_raddr),
    .rdata_o (watch_rdata)
  );

  lae_ram #(.WIDTH(16), .DEPTH(1 << (PAW + EW))) u_tok_ram (
    .clk_i   (clk_i),
    .we_i    (tok_we),
    .waddr_i (tok_waddr),
    .wdata_i (token_value_i),
    .raddr_i (tok_raddr),
    .rdata_o (tok_rdata)
  );

  lae_ram #(.WIDTH(RW), .DEPTH(POINT_COUNT)) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (rec_we),
    .waddr_i (rec_waddr),
    .wdata_i (RW'(rec_n)),
    .raddr_i (rec_raddr),
    .rdata_o (rec_rdata_raw)
  );

  lae_ram #(.WIDTH(STW), .DEPTH(POINT_COUNT)) u_set_ram (
    .clk_i   (clk_i),
    .we_i    (set_we),
    .waddr_i (rec_waddr),
    .wdata_i (STW'(set_n)),
    .raddr_i (rec_raddr),
    .rdata_o (set_rdata_raw)
  );

  always_comb begin
    st_d   = st_q;
    ap_d   = ap_q;
    sel_d  = sel_q;
    sval_d = sval_q;
    pos_d  = pos_q;
    sp_d   = sp_q;
    stk_d  = stk_q;
    cur_d  = cur_q;
    bad_d  = bad_q;
    clr_d  = clr_q;

    done_d    = 1'b0;
    sampled_d = 1'b0;
    outcome_d = R_PASS;
    pstate_d  = PS_UNUSED;
    consec_d  = 16'd0;
    req_d     = 1'b0;
    act_d     = 16'd0;
    flags_d   = 7'd0;

    watch_we    = 1'b0;
    watch_waddr = WAW'(watch_index_i);
    watch_wdata = watch_value_i;
    tok_we      = 1'b0;
    tok_waddr   = {PAW'(ap_index_i), EW'(token_position_i)};
    rec_we      = 1'b0;
    set_we      = 1'b0;
    rec_waddr   = ap_q;
    rec_n       = rec_r;
    set_n       = set_r;

    case (st_q)
      ST_CLR: begin
        rec_waddr   = PAW'(clr_q);
        watch_waddr = WAW'(clr_q);
        watch_wdata = W_STALE;
        rec_n       = '{state: PS_UNUSED, last: R_STALE, default: '0};
        set_n       = '0;
        rec_we      = 32'(clr_q) < POINT_COUNT;
        set_we      = 32'(clr_q) < POINT_COUNT;
        watch_we    = 32'(clr_q) < WATCH_COUNT;
        clr_d       = clr_q + CLW'(1);
        if (clr_q == CLW'(CLRN - 1)) begin
          st_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          ap_d   = PAW'(ap_index_i);
          sel_d  = setting_select_i;
          sval_d = setting_value_i;
          case (operation_i)
            OP_LOAD_WATCH: begin
              watch_we = 32'(watch_index_i) < WATCH_COUNT;
              done_d   = 1'b1;
            end
            OP_LOAD_TOKEN: begin
              tok_we = ap_ok && (32'(token_position_i) < EQUATION_LENGTH);
              done_d = 1'b1;
            end
            OP_LOAD_SET: begin
              if (ap_ok) st_d = ST_SETW;
              else done_d = 1'b1;
            end
            OP_SAMPLE: begin
              if (ap_ok) begin
                st_d = ST_CHK;
              end else begin
                done_d    = 1'b1;
                outcome_d = R_STALE;
              end
            end
            default: done_d = 1'b1;
          endcase
        end
      end
      ST_SETW: begin
        case (sel_q)
          SEL_STATE: begin
            rec_n.state = sval_q[2:0];
            rec_we      = sval_q <= 16'(PS_LAST);
          end
          SEL_FAILS: begin
            set_n.fails = sval_q;
            set_we      = 1'b1;
          end
          SEL_PF: begin
            set_n.pf = sval_q;
            set_we   = 1'b1;
          end
          SEL_FP: begin
            set_n.fp = sval_q;
            set_we   = 1'b1;
          end
          SEL_PASSIVE: begin
            set_n.pas = sval_q;
            set_we    = 1'b1;
          end
          SEL_ACTION: begin
            set_n.action = sval_q;
            set_we       = 1'b1;
          end
          default: ;
        endcase
        done_d = 1'b1;
        st_d   = ST_IDLE;
      end
      ST_CHK: begin
        pos_d = '0;
        sp_d  = '0;
        if (rec_r.state == PS_ACTIVE || rec_r.state == PS_PASSIVE) begin
          st_d = ST_TOK;
        end else begin
          done_d    = 1'b1;
          outcome_d = rec_r.last;
          pstate_d  = rec_r.state;
          consec_d  = (|rec_r.consec[31:16]) ? 16'hFFFF : rec_r.consec[15:0];
          st_d      = ST_IDLE;
        end
      end
      ST_TOK: begin
        bad_d = 1'b0;
        if (pos_q == PW'(EQUATION_LENGTH)) begin
          // ran off the end with no end token
          cur_d = R_ERROR;
          bad_d = 1'b1;
          st_d  = ST_UPD;
        end else if (tok_rdata == TOK_END) begin
          st_d = ST_UPD;
          if (sp_q == '0) begin
            cur_d = R_ERROR;
            bad_d = 1'b1;
          end else if (top_v == W_ERROR) begin
            cur_d = R_ERROR;
          end else if (top_v == W_STALE) begin
            cur_d = R_STALE;
          end else if (sp_q != PW'(1)) begin
            cur_d = R_ERROR;
            bad_d = 1'b1;
          end else begin
            cur_d = (top_v == W_TRUE) ? R_FAIL : R_PASS;
          end
        end else if (tok_rdata == TOK_AND || tok_rdata == TOK_OR ||
                     tok_rdata == TOK_XOR) begin
          if (sp_q < PW'(2)) begin
            cur_d = R_ERROR;
            bad_d = 1'b1;
            st_d  = ST_UPD;
          end else begin
            stk_d      = {2'b00, stk_q[SW-1:2]};
            stk_d[1:0] = combine(tok_rdata, stk_q[3:2], stk_q[1:0]);
            sp_d       = sp_q - PW'(1);
            pos_d      = pos_q + PW'(1);
          end
        end else if (tok_rdata == TOK_NOT) begin
          if (sp_q == '0) begin
            cur_d = R_ERROR;
            bad_d = 1'b1;
            st_d  = ST_UPD;
          end else begin
            if (top_v == W_FALSE) stk_d[1:0] = W_TRUE;
            else if (top_v == W_TRUE) stk_d[1:0] = W_FALSE;
            pos_d = pos_q + PW'(1);
          end
        end else if (32'(tok_rdata) < WATCH_COUNT) begin
          // watch read goes out now, push next cycle
          pos_d = pos_q + PW'(1);
          st_d  = ST_PUSH;
        end else begin
          cur_d = R_ERROR;
          bad_d = 1'b1;
          st_d  = ST_UPD;
        end
      end
      ST_PUSH: begin
        stk_d = {stk_q[SW-3:0], watch_rdata};
        sp_d  = sp_q + PW'(1);
        st_d  = ST_TOK;
      end
      ST_UPD: begin
        rec_n.last = cur_q;
        rec_we     = 1'b1;
        sampled_d  = 1'b1;
        case (cur_q)
          R_FAIL: begin
            rec_n.consec = c1;
            if (rec_r.last == R_PASS) begin
              rec_n.pf = pf1;
              flags_d[FL_PF] = pf1 <= {16'd0, set_r.pf};
            end
            if (c1 >= {16'd0, set_r.fails}) begin
              if (rec_r.state == PS_ACTIVE) begin
                rec_n.state = PS_PASSIVE;
                if (app_q) begin
                  req_d = 1'b1;
                  act_d = set_r.action;
                  flags_d[FL_ACTION] = 1'b1;
                end else begin
                  flags_d[FL_APP_PAS] = 1'b1;
                end
              end else begin
                rec_n.pas = pas1;
                flags_d[FL_PT_PAS] = pas1 <= {16'd0, set_r.pas};
              end
            end
          end
          R_PASS: begin
            if (rec_r.last == R_FAIL) begin
              rec_n.fp = fp1;
              flags_d[FL_FP] = fp1 <= {16'd0, set_r.fp};
            end
            rec_n.consec = '0;
          end
          R_STALE: rec_n.consec = '0;
          default: flags_d[FL_ERROR] = 1'b1;
        endcase
        flags_d[FL_BAD] = bad_q;
        done_d    = 1'b1;
        outcome_d = cur_q;
        pstate_d  = rec_n.state;
        consec_d  = (|rec_n.consec[31:16]) ? 16'hFFFF : rec_n.consec[15:0];
        st_d      = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_CLR;
      clr_q   <= '0;
      app_q   <= 1'b1;
      done_q  <= 1'b0;
    end else begin
      st_q   <= st_d;
      clr_q  <= clr_d;
      done_q <= done_d;
      if (app_active_we_i) begin
        app_q <= app_active_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ap_q      <= ap_d;
    sel_q     <= sel_d;
    sval_q    <= sval_d;
    pos_q     <= pos_d;
    sp_q      <= sp_d;
    stk_q     <= stk_d;
    cur_q     <= cur_d;
    bad_q     <= bad_d;
    sampled_q <= sampled_d;
    outcome_q <= outcome_d;
    pstate_q  <= pstate_d;
    consec_q  <= consec_d;
    req_q     <= req_d;
    act_q     <= act_d;
    flags_q   <= flags_d;
  end

  assign busy_o              = st_q != ST_IDLE;
  assign done_o              = done_q;
  assign sampled_o           = sampled_q;
  assign outcome_o           = outcome_q;
  assign point_state_o       = pstate_q;
  assign consecutive_fails_o = consec_q;
  assign request_action_o    = req_q;
  assign action_id_o         = act_q;
  assign event_flags_o       = flags_q;

endmodule

`default_nettype wire

### hw/rtl/lae_ram.sv
// ----------------------------------------------------------------------------
// lae_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lae_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                         wdata_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### hw/rtl/lae_checker.sv
// ----------------------------------------------------------------------------
// lae_checker
// Port-level checks on the result beats of the actionpoint evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

module lae_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        done_o,
  input wire logic        sampled_o,
  input wire logic [1:0]  outcome_o,
  input wire logic [2:0]  point_state_o,
  input wire logic [15:0] consecutive_fails_o,
  input wire logic        request_action_o,
  input wire logic [15:0] action_id_o,
  input wire logic [6:0]  event_flags_o
);

  import lae_pkg::*;

  a_req_sampled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && request_action_o |-> sampled_o && point_state_o == PS_PASSIVE
                                   && outcome_o == R_FAIL)
    else $error("action request without a failing sample");

  a_unsampled_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !sampled_o |-> !request_action_o && action_id_o == 16'd0
                             && event_flags_o == 7'd0)
    else $error("unsampled beat carries action or flags");

  a_pass_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && sampled_o && (outcome_o == R_PASS || outcome_o == R_STALE)
      |-> consecutive_fails_o == 16'd0)
    else $error("pass or stale beat with nonzero fail count");

  a_bad_is_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && event_flags_o[FL_BAD] |-> event_flags_o[FL_ERROR] && outcome_o == R_ERROR)
    else $error("bad equation flag without error outcome");

endmodule

bind limit_actionpoint_evaluator_top lae_checker u_lae_checker (.*);

`default_nettype wire
